>>> design/stack_machine_executor_defines.svh
// ---------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shared macros for the concurrent checks on the executor ports.
// They expect clk and rst to be visible where they are used.
// ---------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

// Same-cycle implication.
`define SME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sme_pkg.sv
// ---------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, result kinds and the command and status types shared by the
// controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

  localparam int DATA_W          = 32;
  localparam int OPC_W           = 4;
  localparam int KIND_W          = 4;
  localparam int IDX_W           = 3;
  localparam int MAX_DUMP        = 8;
  localparam int STACK_DEPTH_DEF = 8;

  localparam logic [DATA_W-1:0] PASS_KEY_RESET = 32'h0003_1337;

  localparam logic [OPC_W-1:0] OP_PUSH  = 4'd0;
  localparam logic [OPC_W-1:0] OP_POP   = 4'd1;
  localparam logic [OPC_W-1:0] OP_ADD   = 4'd2;
  localparam logic [OPC_W-1:0] OP_SUB   = 4'd3;
  localparam logic [OPC_W-1:0] OP_DIV   = 4'd4;
  localparam logic [OPC_W-1:0] OP_MUL   = 4'd5;
  localparam logic [OPC_W-1:0] OP_ENTER = 4'd6;
  localparam logic [OPC_W-1:0] OP_TEST  = 4'd7;
  localparam logic [OPC_W-1:0] OP_PRINT = 4'd8;
  localparam logic [OPC_W-1:0] OP_DUMP  = 4'd9;
  localparam logic [OPC_W-1:0] OP_EXIT  = 4'd10;

  localparam logic [KIND_W-1:0] K_POPPED  = 4'd0;
  localparam logic [KIND_W-1:0] K_PRINT   = 4'd1;
  localparam logic [KIND_W-1:0] K_DUMP    = 4'd2;
  localparam logic [KIND_W-1:0] K_PASS    = 4'd3;
  localparam logic [KIND_W-1:0] K_FAIL    = 4'd4;
  localparam logic [KIND_W-1:0] K_FULL    = 4'd5;
  localparam logic [KIND_W-1:0] K_EMPTY   = 4'd6;
  localparam logic [KIND_W-1:0] K_DIVZERO = 4'd7;
  localparam logic [KIND_W-1:0] K_EXIT    = 4'd8;
  localparam logic [KIND_W-1:0] K_HALTED  = 4'd9;

  typedef enum logic {WR_OPERAND, WR_RESULT} wr_sel_t;
  typedef enum logic {VAL_ZERO, VAL_READ} val_sel_t;
  typedef enum logic [1:0] {RES_ADD, RES_SUB, RES_MUL, RES_DIV} res_sel_t;

  typedef struct packed {
    logic              wr_en;
    wr_sel_t           wr_sel;
    logic              load_a;
    logic              load_b;
    logic              load_res;
    res_sel_t          res_sel;
    logic              div_start;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              last;
    val_sel_t          val_sel;
  } cmd_t;

  typedef struct packed {
    logic key_match;
    logic b_zero;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

>>> design/stack_machine_executor.sv
// ---------------------------------------------------------------------------
// Stack machine executor
// Runs one instruction per accepted word on a stack of signed 32-bit words
// and reports popped, printed, dumped and status words on the result port.
//
//   Channel   Signals                                    Transfer
//   command   start, busy, opcode, operand_value         start & !busy
//   config    cfg_valid, cfg_ready, cfg_data             cfg_valid & cfg_ready
//   result    result_strobe, result_kind, entry_index,   result_strobe
//             entry_value, last_result
//
// Push, enter, exit, halted and ignored opcodes finish from idle; pop, test
// and print read the top; add, sub and mul read, compute and write back;
// a dump streams its words; divide uses the radix-2 divider, one bit a cycle.
// Each result word is held for one cycle; the receiver cannot stall it.
// Reset clears the stack depth, the halt flag and the key to its default.
// ---------------------------------------------------------------------------
`default_nettype none

module stack_machine_executor
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [OPC_W-1:0]         opcode,
  input  wire logic signed [DATA_W-1:0] operand_value,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic signed [DATA_W-1:0] cfg_data,
  output logic                          result_strobe,
  output logic      [KIND_W-1:0]        result_kind,
  output logic      [IDX_W-1:0]         entry_index,
  output logic signed [DATA_W-1:0]      entry_value,
  output logic                          last_result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  cmd_t             cmd;
  status_t          stat;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [IDX_W-1:0] out_index;

  assign cfg_ready = 1'b1;

  sme_ctrl #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .busy      (busy),
    .cmd       (cmd),
    .stat      (stat),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .out_index (out_index)
  );

  sme_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .operand_value (operand_value),
    .cmd           (cmd),
    .stat          (stat),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .out_index     (out_index),
    .result_strobe (result_strobe),
    .result_kind   (result_kind),
    .entry_index   (entry_index),
    .entry_value   (entry_value),
    .last_result   (last_result)
  );

endmodule

`default_nettype wire

>>> design/sme_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                         wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/sme_div.sv
// ---------------------------------------------------------------------------
// Stack machine executor divider
// Signed 32-bit division truncating toward zero, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sme_div
  import sme_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] dividend,
  input  wire logic [DATA_W-1:0] divisor,
  output logic                   done,
  output logic      [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              run;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] mag_b;
  logic              neg;
  logic [DATA_W:0]   shifted;
  logic              ge;

  assign shifted  = {rem[DATA_W-1:0], quo[DATA_W-1]};
  assign ge       = shifted >= {1'b0, mag_b};
  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DATA_W - 1);
        rem <= '0;
        quo <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
        mag_b <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
        neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (run) begin
        rem <= ge ? (shifted - {1'b0, mag_b}) : shifted;
        quo <= {quo[DATA_W-2:0], ge};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sme_datapath.sv
// ---------------------------------------------------------------------------
// Stack machine executor datapath
// Stack memory, operand and result registers, divider, key register and
// the registered result port.
// ---------------------------------------------------------------------------
`default_nettype none

module sme_datapath
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  input  wire logic signed [DATA_W-1:0]  cfg_data,
  input  wire logic signed [DATA_W-1:0]  operand_value,
  input  wire cmd_t                      cmd,
  output status_t                        stat,
  input  wire logic [((STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [((STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1)-1:0] rd_addr,
  input  wire logic [IDX_W-1:0]          out_index,
  output logic                           result_strobe,
  output logic      [KIND_W-1:0]         result_kind,
  output logic      [IDX_W-1:0]          entry_index,
  output logic signed [DATA_W-1:0]       entry_value,
  output logic                           last_result
);

  logic [DATA_W-1:0] pass_key;
  logic [DATA_W-1:0] a_reg;
  logic [DATA_W-1:0] b_reg;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] res_next;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] div_q;
  logic              div_done;

  sme_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sme_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (a_reg),
    .divisor  (b_reg),
    .done     (div_done),
    .quotient (div_q)
  );

  assign wr_data = (cmd.wr_sel == WR_OPERAND) ? $unsigned(operand_value) : res;
  assign prod    = a_reg * b_reg;

  assign stat.key_match = rd_data == pass_key;
  assign stat.b_zero    = rd_data == '0;
  assign stat.div_done  = div_done;

  always_comb begin
    case (cmd.res_sel)
      RES_ADD: res_next = a_reg + b_reg;
      RES_SUB: res_next = a_reg - b_reg;
      RES_MUL: res_next = prod;
      RES_DIV: res_next = div_q;
      default: res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_key      <= PASS_KEY_RESET;
      result_strobe <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pass_key <= $unsigned(cfg_data);
      end
      result_strobe <= cmd.emit;
    end
    if (cmd.load_a) begin
      a_reg <= rd_data;
    end
    if (cmd.load_b) begin
      b_reg <= rd_data;
    end
    if (cmd.load_res) begin
      res <= res_next;
    end
    if (cmd.emit) begin
      result_kind <= cmd.kind;
      entry_index <= out_index;
      entry_value <= (cmd.val_sel == VAL_READ) ? $signed(rd_data) : '0;
      last_result <= cmd.last;
    end
  end

endmodule

`default_nettype wire

>>> design/sme_ctrl.sv
// ---------------------------------------------------------------------------
// Stack machine executor controller
// Decodes each instruction, keeps the stack depth and halt flag, generates
// memory addresses and sequences the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module sme_ctrl
  import sme_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [OPC_W-1:0]  opcode,
  output logic                   busy,
  output cmd_t                   cmd,
  input  wire status_t           stat,
  output logic [((STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1)-1:0] wr_addr,
  output logic [((STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1)-1:0] rd_addr,
  output logic [IDX_W-1:0]       out_index
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ_A, S_READ_B, S_EXEC, S_DIV, S_WRITE, S_DUMP
  } state_t;

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic             halted, halted_next;
  logic [OPC_W-1:0] op, op_next;
  logic [AW-1:0]    ptr, ptr_next;
  logic [3:0]       left, left_next;

  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    cnt_m2;
  logic [AW-1:0]    top_addr;
  logic [AW-1:0]    nxt_addr;
  logic [AW+2:0]    top_ext;
  logic [AW+2:0]    ptr_ext;
  logic [CW+3:0]    cnt_ext;
  logic [3:0]       left_init;
  logic             full;

  assign cnt_m1    = count - CW'(1);
  assign cnt_m2    = count - CW'(2);
  assign top_addr  = cnt_m1[AW-1:0];
  assign nxt_addr  = cnt_m2[AW-1:0];
  assign top_ext   = {3'b000, top_addr};
  assign ptr_ext   = {3'b000, ptr};
  assign cnt_ext   = {4'b0000, count};
  assign left_init = (cnt_ext >= (CW + 4)'(MAX_DUMP)) ? 4'(MAX_DUMP) : cnt_ext[3:0];
  assign full      = count == CW'(STACK_DEPTH);
  assign busy      = state != S_IDLE;

  always_comb begin
    state_next  = state;
    count_next  = count;
    halted_next = halted;
    op_next     = op;
    ptr_next    = ptr;
    left_next   = left;
    cmd         = '0;
    rd_addr     = top_addr;
    wr_addr     = top_addr;
    out_index   = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          op_next = opcode;
          if (halted) begin
            cmd.emit = 1'b1;
            cmd.kind = K_HALTED;
            cmd.last = 1'b1;
          end else begin
            case (opcode)
              OP_PUSH, OP_ENTER: begin
                if (full) begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_FULL;
                  cmd.last = 1'b1;
                end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = WR_OPERAND;
                  wr_addr    = count[AW-1:0];
                  count_next = count + CW'(1);
                end
              end
              OP_POP, OP_TEST, OP_PRINT: begin
                if (count == '0) begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_EMPTY;
                  cmd.last = 1'b1;
                end else begin
                  state_next = S_READ_A;
                end
              end
              OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
                if (count < CW'(2)) begin
                  cmd.emit = 1'b1;
                  cmd.kind = K_EMPTY;
                  cmd.last = 1'b1;
                end else begin
                  state_next = S_READ_A;
                end
              end
              OP_DUMP: begin
                if (count != '0) begin
                  ptr_next   = top_addr;
                  left_next  = left_init;
                  state_next = S_DUMP;
                end
              end
              OP_EXIT: begin
                halted_next = 1'b1;
                cmd.emit    = 1'b1;
                cmd.kind    = K_EXIT;
                cmd.last    = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_READ_A: begin
        case (op)
          OP_POP, OP_TEST, OP_PRINT: begin
            cmd.emit    = 1'b1;
            cmd.last    = 1'b1;
            cmd.val_sel = VAL_READ;
            out_index   = top_ext[2:0];
            state_next  = S_IDLE;
            if (op == OP_PRINT) begin
              cmd.kind = K_PRINT;
            end else begin
              count_next = cnt_m1;
              if (op == OP_TEST) begin
                cmd.kind = stat.key_match ? K_PASS : K_FAIL;
              end else begin
                cmd.kind = K_POPPED;
              end
            end
          end
          default: begin
            cmd.load_a = 1'b1;
            rd_addr    = nxt_addr;
            state_next = S_READ_B;
          end
        endcase
      end
      S_READ_B: begin
        cmd.load_b = 1'b1;
        if (op == OP_DIV && stat.b_zero) begin
          cmd.emit   = 1'b1;
          cmd.kind   = K_DIVZERO;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op)
          OP_DIV: begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
          OP_SUB: begin
            cmd.load_res = 1'b1;
            cmd.res_sel  = RES_SUB;
            state_next   = S_WRITE;
          end
          OP_MUL: begin
            cmd.load_res = 1'b1;
            cmd.res_sel  = RES_MUL;
            state_next   = S_WRITE;
          end
          default: begin
            cmd.load_res = 1'b1;
            cmd.res_sel  = RES_ADD;
            state_next   = S_WRITE;
          end
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.load_res = 1'b1;
          cmd.res_sel  = RES_DIV;
          state_next   = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_RESULT;
        wr_addr    = nxt_addr;
        count_next = cnt_m1;
        state_next = S_IDLE;
      end
      S_DUMP: begin
        cmd.emit    = 1'b1;
        cmd.kind    = K_DUMP;
        cmd.val_sel = VAL_READ;
        cmd.last    = left == 4'd1;
        out_index   = ptr_ext[2:0];
        rd_addr     = ptr - AW'(1);
        if (left == 4'd1) begin
          state_next = S_IDLE;
        end else begin
          ptr_next  = ptr - AW'(1);
          left_next = left - 4'd1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      halted <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      halted <= halted_next;
    end
    op   <= op_next;
    ptr  <= ptr_next;
    left <= left_next;
  end

endmodule

`default_nettype wire

>>> design/sme_checker.sv
// ---------------------------------------------------------------------------
// Stack machine executor checker
// Port-level checks on result word framing, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stack_machine_executor_defines.svh"

module sme_checker
  import sme_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     result_strobe,
  input wire logic [KIND_W-1:0]        result_kind,
  input wire logic [IDX_W-1:0]         entry_index,
  input wire logic signed [DATA_W-1:0] entry_value,
  input wire logic                     last_result
);

  logic status_kind;
  logic lone_word;
  logic mid_word;
  logic dump_word;

  assign status_kind = result_kind == K_EXIT || result_kind == K_HALTED ||
                       result_kind == K_FULL || result_kind == K_EMPTY ||
                       result_kind == K_DIVZERO;
  assign lone_word   = last_result && entry_index == '0 && entry_value == '0;
  assign mid_word    = result_strobe && !last_result;
  assign dump_word   = result_strobe && result_kind == K_DUMP;

  `SME_ASSERT_IMP(a_status_single, result_strobe && status_kind, lone_word, "status word has a value")

  `SME_ASSERT_IMP(a_multi_is_dump, mid_word, result_kind == K_DUMP, "only a dump has several words")

  `SME_ASSERT_NXT(a_dump_continues, mid_word, dump_word, "dump sequence broken early")

  `SME_ASSERT_IMP(a_word_has_cause, result_strobe, $past(busy) || $past(start), "word without a command")

endmodule

bind stack_machine_executor sme_checker u_sme_checker (.*);

`default_nettype wire

>>> tb/tb_stack_machine_executor.sv
// ---------------------------------------------------------------------------
// Stack machine executor testbench
// Drives instruction words through the command port, predicts every result
// word from a behavioral copy of the stack, and checks each strobed result
// in order. The pass key is rewritten between phases while the block idles.
// ---------------------------------------------------------------------------
module tb_stack_machine_executor;
  import sme_pkg::*;

  localparam int STACK_SLOTS = STACK_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [OPC_W-1:0]  opc;
    logic [DATA_W-1:0] val;
  } instr_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic              last;
  } result_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OPC_W-1:0] opcode = '0;
  logic signed [DATA_W-1:0] operand_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [DATA_W-1:0] cfg_data = '0;
  logic result_strobe;
  logic [KIND_W-1:0] result_kind;
  logic [IDX_W-1:0] entry_index;
  logic signed [DATA_W-1:0] entry_value;
  logic last_result;

  instr_t pending_instrs[$];
  result_word_t expected_words[$];

  logic [DATA_W-1:0] stack_mem[STACK_SLOTS];
  int stack_depth = 0;
  bit machine_halted = 1'b0;
  logic [DATA_W-1:0] pass_key_model = PASS_KEY_RESET;

  bit cmd_taken = 1'b0;
  int send_idle_pct = 0;
  int idle_cycles = 0;
  int errors = 0;
  int instr_count = 0;
  int result_count = 0;
  int key_writes = 0;
  bit [15:0] kinds_seen = '0;

  stack_machine_executor u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .operand_value(operand_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .result_kind(result_kind),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .last_result(last_result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic result_word_t word_of(input logic [KIND_W-1:0] kind,
                                           input int idx,
                                           input logic [DATA_W-1:0] value);
    result_word_t w;
    w.kind = kind;
    w.idx = IDX_W'(idx);
    w.value = value;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic void execute_instr(input logic [OPC_W-1:0] opc,
                                        input logic [DATA_W-1:0] val);
    result_word_t words[$];
    logic [DATA_W-1:0] a, b, r, ma, mb, q;
    logic [KIND_W-1:0] kind;
    int i;
    if (machine_halted) begin
      words.push_back(word_of(K_HALTED, 0, '0));
    end else begin
      case (opc)
        OP_PUSH, OP_ENTER: begin
          if (stack_depth >= STACK_SLOTS) begin
            words.push_back(word_of(K_FULL, 0, '0));
          end else begin
            stack_mem[stack_depth] = val;
            stack_depth++;
          end
        end
        OP_POP, OP_TEST: begin
          if (stack_depth == 0) begin
            words.push_back(word_of(K_EMPTY, 0, '0));
          end else begin
            stack_depth--;
            kind = K_POPPED;
            if (opc == OP_TEST) begin
              kind = (stack_mem[stack_depth] == pass_key_model) ? K_PASS : K_FAIL;
            end
            words.push_back(word_of(kind, stack_depth, stack_mem[stack_depth]));
          end
        end
        OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
          if (stack_depth < 2) begin
            words.push_back(word_of(K_EMPTY, 0, '0));
          end else begin
            a = stack_mem[stack_depth-1];
            b = stack_mem[stack_depth-2];
            if (opc == OP_DIV && b == '0) begin
              words.push_back(word_of(K_DIVZERO, 0, '0));
            end else begin
              case (opc)
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                default: begin
                  ma = a[DATA_W-1] ? -a : a;
                  mb = b[DATA_W-1] ? -b : b;
                  q = ma / mb;
                  r = (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
                end
              endcase
              stack_depth--;
              stack_mem[stack_depth-1] = r;
            end
          end
        end
        OP_PRINT: begin
          if (stack_depth == 0) begin
            words.push_back(word_of(K_EMPTY, 0, '0));
          end else begin
            words.push_back(word_of(K_PRINT, stack_depth - 1, stack_mem[stack_depth-1]));
          end
        end
        OP_DUMP: begin
          for (i = stack_depth - 1; i >= 0 && words.size() < MAX_DUMP; i--) begin
            words.push_back(word_of(K_DUMP, i, stack_mem[i]));
          end
        end
        OP_EXIT: begin
          machine_halted = 1'b1;
          words.push_back(word_of(K_EXIT, 0, '0));
        end
        default: ;
      endcase
    end
    if (words.size() > 0) begin
      words[words.size()-1].last = 1'b1;
    end
    foreach (words[i]) begin
      expected_words.push_back(words[i]);
    end
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_val,
                                      input logic [DATA_W-1:0] got_val);
    if (got_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(exp_val), $signed(got_val));
    end
  endfunction

  always @(negedge clk) begin
    if (!rst && (!start || cmd_taken)) begin
      if (pending_instrs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        opcode <= pending_instrs[0].opc;
        operand_value <= pending_instrs[0].val;
        void'(pending_instrs.pop_front());
      end else begin
        start <= 1'b0;
      end
      cmd_taken = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (start && busy === 1'b0) begin
        execute_instr(opcode, operand_value);
        cmd_taken = 1'b1;
        instr_count++;
        idle_cycles = 0;
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        idle_cycles = 0;
      end
      if (result_strobe === 1'b1) begin
        idle_cycles = 0;
        result_count++;
        kinds_seen[result_kind] = 1'b1;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, kind %0d index %0d value %0d last %0b",
                   $time, result_kind, entry_index, entry_value, last_result);
        end else begin
          check_field("result_kind", DATA_W'(expected_words[0].kind), DATA_W'(result_kind));
          check_field("entry_index", DATA_W'(expected_words[0].idx), DATA_W'(entry_index));
          check_field("entry_value", expected_words[0].value, entry_value);
          check_field("last_result", DATA_W'(expected_words[0].last), DATA_W'(last_result));
          void'(expected_words.pop_front());
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic void queue_instr(input logic [OPC_W-1:0] opc,
                                      input logic [DATA_W-1:0] val);
    instr_t it;
    it.opc = opc;
    it.val = val;
    pending_instrs.push_back(it);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return pass_key_model;
      1: begin
        case ($urandom_range(4))
          0: return '0;
          1: return DATA_W'(1);
          2: return '1;
          3: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      2: return DATA_W'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  // Bursts lean at random toward filling or draining so the stack depth
  // swings across its whole range, including full and empty.
  task automatic queue_random(input int count);
    logic [OPC_W-1:0] drain_ops[8];
    logic [OPC_W-1:0] op;
    int i;
    int fill_pct;
    int r;
    drain_ops = '{OP_POP, OP_ADD, OP_SUB, OP_DIV, OP_MUL, OP_TEST, OP_PRINT, OP_DUMP};
    fill_pct = 20;
    for (i = 0; i < count; i++) begin
      if (i % 12 == 0) begin
        fill_pct = $urandom_range(1) ? 60 : 20;
      end
      r = $urandom_range(99);
      if (r < 4) begin
        queue_instr(OPC_W'($urandom_range(15, 11)), $urandom());
      end else if (r < 4 + fill_pct) begin
        queue_instr($urandom_range(1) ? OP_PUSH : OP_ENTER, pick_value());
      end else begin
        op = drain_ops[$urandom_range(7)];
        if (op == OP_TEST && $urandom_range(1)) begin
          queue_instr(OP_PUSH, pass_key_model);
        end
        queue_instr(op, $urandom());
      end
    end
  endtask

  task automatic drain_phase();
    while (pending_instrs.size() > 0 || start) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pass_key(input logic [DATA_W-1:0] key);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= key;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pass_key_model = key;
    key_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    queue_instr(OP_POP, '0);
    queue_instr(OP_PRINT, '0);
    queue_instr(OP_ADD, '0);
    queue_instr(OP_DUMP, '0);
    queue_instr(OP_PUSH, PASS_KEY_RESET);
    queue_instr(OP_TEST, '0);
    queue_instr(OP_PUSH, '1);
    queue_instr(OP_PUSH, 32'h8000_0000);
    queue_instr(OP_DIV, '0);
    queue_instr(OP_ENTER, '0);
    queue_instr(OP_PUSH, DATA_W'(7));
    queue_instr(OP_DIV, '0);
    queue_instr(OP_MUL, '0);
    queue_instr(OP_SUB, '0);
    queue_instr(OP_PUSH, 32'h7fff_ffff);
    queue_instr(OP_PUSH, 32'h7fff_ffff);
    queue_instr(OP_ENTER, 32'h8000_0000);
    queue_instr(OP_PUSH, 32'h5555_5555);
    queue_instr(OP_ENTER, 32'haaaa_aaaa);
    queue_instr(OP_PUSH, DATA_W'(1));
    queue_instr(OP_PUSH, '1);
    queue_instr(OP_PUSH, '0);
    queue_instr(OP_DUMP, '0);
    queue_instr(OP_TEST, '0);
    queue_instr(OP_MUL, '0);
    queue_random(100);
    drain_phase();

    write_pass_key(32'h8000_0000);
    send_idle_pct = 57;
    queue_random(120);
    drain_phase();

    write_pass_key(32'h7fff_ffff);
    send_idle_pct = 0;
    queue_random(60);
    drain_phase();

    write_pass_key('0);
    queue_random(30);
    drain_phase();

    write_pass_key($urandom());
    queue_random(30);
    queue_instr(OP_EXIT, $urandom());
    repeat (3) queue_instr(OPC_W'($urandom_range(15)), $urandom());
    drain_phase();

    $display("Executed %0d instructions and checked %0d result words, %0d mismatches.",
             instr_count, result_count, errors);
    $display("Saw %0d of 10 result kinds under %0d pass key settings.",
             $countones(kinds_seen), key_writes + 1);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
